/* hdl/urbe_pkg.sv */
package urbe_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_EVENT = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       rx_ready;
		logic       rx_error;
		logic       tx_ready;
	} req_item_t;

	typedef struct packed {
		logic       tx_load;
		logic [7:0] tx_byte;
		logic [7:0] read_data;
		logic       read_valid;
		logic       write_accepted;
		logic       clear_errors;
		logic       tx_irq_enable;
		logic [7:0] tx_level;
		logic [7:0] rx_level;
	} rsp_item_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

/* hdl/urbe_req_if.sv */
interface urbe_req_if;
	logic                valid;
	logic                ready;
	urbe_pkg::req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hdl/urbe_rsp_if.sv */
interface urbe_rsp_if;
	logic                valid;
	logic                ready;
	urbe_pkg::rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hdl/urbe_ctrl.sv */
module urbe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  urbe_pkg::dp_sts_t  sts,
	output urbe_pkg::ctl_cmd_t cmd
);

	urbe_pkg::state_t state_q;
	urbe_pkg::state_t state_d;

	always_comb begin
		req_ready  = (state_q == urbe_pkg::S_IDLE);
		cmd.accept = req_valid && req_ready;
		// commit only when the output register can take the result
		cmd.commit = (state_q == urbe_pkg::S_EXEC) && !sts.out_busy;
		state_d    = state_q;
		case (state_q)
			urbe_pkg::S_IDLE: begin
				if (cmd.accept) state_d = urbe_pkg::S_EXEC;
			end
			urbe_pkg::S_EXEC: begin
				if (cmd.commit) state_d = urbe_pkg::S_IDLE;
			end
			default: state_d = urbe_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= urbe_pkg::S_IDLE;
		else state_q <= state_d;
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register lost one-hot code");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == urbe_pkg::S_EXEC))
		else $error("accepted beat did not move to execute");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in the same cycle");

endmodule

/* hdl/urbe_datapath.sv */
module urbe_datapath #(
	parameter int DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  urbe_pkg::ctl_cmd_t  cmd,
	output urbe_pkg::dp_sts_t   sts,
	input  urbe_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output urbe_pkg::rsp_item_t rsp_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [7:0] tx_mem [DEPTH];
	logic [7:0] rx_mem [DEPTH];

	urbe_pkg::req_item_t item_q;
	logic [AW-1:0] tx_rd_ptr_q, tx_wr_ptr_q, rx_rd_ptr_q, rx_wr_ptr_q;
	logic [CW-1:0] tx_cnt_q, rx_cnt_q;
	logic          tx_running_q, tie_q;
	logic [7:0]    tx_rdata_q, rx_rdata_q;
	logic          rsp_valid_q;
	urbe_pkg::rsp_item_t rsp_q;

	logic [AW-1:0] tx_rd_ptr_d, tx_wr_ptr_d, rx_rd_ptr_d, rx_wr_ptr_d;
	logic [CW-1:0] tx_cnt_d, rx_cnt_d;
	logic          tx_running_d, tie_d;
	logic          tx_push, rx_push;
	logic [LW-1:0] tx_lvl, rx_lvl;
	urbe_pkg::rsp_item_t rsp_d;

	always_comb begin
		tx_rd_ptr_d  = tx_rd_ptr_q;
		tx_wr_ptr_d  = tx_wr_ptr_q;
		rx_rd_ptr_d  = rx_rd_ptr_q;
		rx_wr_ptr_d  = rx_wr_ptr_q;
		tx_cnt_d     = tx_cnt_q;
		rx_cnt_d     = rx_cnt_q;
		tx_running_d = tx_running_q;
		tie_d        = tie_q;
		tx_push      = 1'b0;
		rx_push      = 1'b0;
		rsp_d        = '0;
		case (urbe_pkg::func_t'(item_q.func))
			urbe_pkg::FUNC_WRITE: begin
				if (tx_cnt_q < FULL) begin
					if (tx_running_q) begin
						tx_push     = 1'b1;
						tx_wr_ptr_d = (tx_wr_ptr_q == LAST) ? '0 : tx_wr_ptr_q + 1'b1;
						tx_cnt_d    = tx_cnt_q + 1'b1;
					end else begin
						// transmitter idle: load the byte directly
						rsp_d.tx_load = 1'b1;
						rsp_d.tx_byte = item_q.data_byte;
						tx_running_d  = 1'b1;
					end
					tie_d                = 1'b1;
					rsp_d.write_accepted = 1'b1;
				end
			end
			urbe_pkg::FUNC_READ: begin
				if (rx_cnt_q != '0) begin
					rsp_d.read_data  = rx_rdata_q;
					rsp_d.read_valid = 1'b1;
					rx_rd_ptr_d      = (rx_rd_ptr_q == LAST) ? '0 : rx_rd_ptr_q + 1'b1;
					rx_cnt_d         = rx_cnt_q - 1'b1;
				end
			end
			urbe_pkg::FUNC_EVENT: begin
				if (item_q.rx_ready || item_q.rx_error) begin
					if (item_q.rx_ready) begin
						// drop the byte when the ring is full
						if (rx_cnt_q < FULL) begin
							rx_push     = 1'b1;
							rx_wr_ptr_d = (rx_wr_ptr_q == LAST) ? '0 : rx_wr_ptr_q + 1'b1;
							rx_cnt_d    = rx_cnt_q + 1'b1;
						end
					end else begin
						rsp_d.clear_errors = 1'b1;
					end
				end else if (item_q.tx_ready) begin
					if (tx_cnt_q != '0) begin
						rsp_d.tx_load = 1'b1;
						rsp_d.tx_byte = tx_rdata_q;
						tx_rd_ptr_d   = (tx_rd_ptr_q == LAST) ? '0 : tx_rd_ptr_q + 1'b1;
						tx_cnt_d      = tx_cnt_q - 1'b1;
					end else begin
						tx_running_d = 1'b0;
						tie_d        = 1'b0;
					end
				end
			end
			default: ;
		endcase
		tx_lvl              = LW'(tx_cnt_d);
		rx_lvl              = LW'(rx_cnt_d);
		rsp_d.tx_irq_enable = tie_d;
		rsp_d.tx_level      = tx_lvl[7:0];
		rsp_d.rx_level      = rx_lvl[7:0];
	end

	// rings: read at the current head when the beat is accepted, write on commit
	always_ff @(posedge clk) begin
		if (cmd.commit && tx_push) tx_mem[tx_wr_ptr_q] <= item_q.data_byte;
		if (cmd.accept) tx_rdata_q <= tx_mem[tx_rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && rx_push) rx_mem[rx_wr_ptr_q] <= item_q.data_byte;
		if (cmd.accept) rx_rdata_q <= rx_mem[rx_rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= req_item;
		if (cmd.commit) rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rd_ptr_q  <= '0;
			tx_wr_ptr_q  <= '0;
			rx_rd_ptr_q  <= '0;
			rx_wr_ptr_q  <= '0;
			tx_cnt_q     <= '0;
			rx_cnt_q     <= '0;
			tx_running_q <= 1'b0;
			tie_q        <= 1'b1;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				tx_rd_ptr_q  <= tx_rd_ptr_d;
				tx_wr_ptr_q  <= tx_wr_ptr_d;
				rx_rd_ptr_q  <= rx_rd_ptr_d;
				rx_wr_ptr_q  <= rx_wr_ptr_d;
				tx_cnt_q     <= tx_cnt_d;
				rx_cnt_q     <= rx_cnt_d;
				tx_running_q <= tx_running_d;
				tie_q        <= tie_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_item     = rsp_q;

	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n) tx_cnt_q <= FULL)
		else $error("transmit ring count above depth");
	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n) rx_cnt_q <= FULL)
		else $error("receive ring count above depth");
	a_queue_running: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_cnt_q != '0) |-> tx_running_q)
		else $error("bytes queued while transmitter stopped");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before taken");

endmodule

/* hdl/uart_ring_buffer_engine.sv */
// Buffered UART data path with a transmit ring and a receive ring of DEPTH bytes each.
// A request beat is a host write (func 0), a host read (func 1) or a UART interrupt
// event (func 2); each request yields exactly one response beat carrying the transmit
// load, the popped byte, status flags and both ring levels after the step. A request
// is first accepted, with the ring heads read from the ring memories, then committed,
// which updates pointers and counts and loads the response register. The next request
// is accepted while the previous response still waits to be taken; the engine holds
// in the commit step only while the response register is full and not being taken.
// Ring levels above 255 are reported in their low eight bits.
module uart_ring_buffer_engine #(
	parameter int DEPTH = 128
) (
	input logic        clk,
	input logic        arst_n,
	urbe_req_if.sink   req,
	urbe_rsp_if.source rsp
);

	urbe_pkg::ctl_cmd_t cmd;
	urbe_pkg::dp_sts_t  sts;

	urbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	urbe_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_item  (req.item),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_item  (rsp.item)
	);

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH = 128;
	localparam int LIMIT = 200000;
	localparam int STALL_CYCLES = 250;

	typedef enum int {
		MIX_TX_FILL,
		MIX_RX_FILL,
		MIX_TX_DRAIN,
		MIX_RX_DRAIN,
		MIX_ANY
	} mix_t;

	logic clk;
	logic arst_n;

	urbe_req_if req_ch ();
	urbe_rsp_if rsp_ch ();

	uart_ring_buffer_engine #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// expected UART engine state
	logic [7:0] tx_ring [DEPTH];
	logic [7:0] rx_ring [DEPTH];
	int         tx_head, tx_tail, tx_fill;
	int         rx_head, rx_tail, rx_fill;
	logic       tx_busy;
	logic       irq_en;

	urbe_pkg::req_item_t beat_q [$];
	urbe_pkg::rsp_item_t rsp_due_q [$];
	int         total_beats;
	int         n_sent;
	logic       req_fire;
	int         errors;
	int         cycles;
	int         stall_left;
	logic       stall_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic urbe_pkg::rsp_item_t uart_step(urbe_pkg::req_item_t r);
		urbe_pkg::rsp_item_t o;
		o = '0;
		case (urbe_pkg::func_t'(r.func))
			urbe_pkg::FUNC_WRITE: begin
				if (tx_fill < DEPTH) begin
					if (tx_busy) begin
						tx_ring[tx_tail] = r.data_byte;
						tx_tail = (tx_tail + 1) % DEPTH;
						tx_fill++;
					end else begin
						o.tx_load = 1'b1;
						o.tx_byte = r.data_byte;
						tx_busy = 1'b1;
					end
					irq_en = 1'b1;
					o.write_accepted = 1'b1;
				end
			end
			urbe_pkg::FUNC_READ: begin
				if (rx_fill != 0) begin
					o.read_data = rx_ring[rx_head];
					o.read_valid = 1'b1;
					rx_head = (rx_head + 1) % DEPTH;
					rx_fill--;
				end
			end
			urbe_pkg::FUNC_EVENT: begin
				if (r.rx_ready || r.rx_error) begin
					if (r.rx_ready) begin
						// drop the byte when the ring is full
						if (rx_fill < DEPTH) begin
							rx_ring[rx_tail] = r.data_byte;
							rx_tail = (rx_tail + 1) % DEPTH;
							rx_fill++;
						end
					end else begin
						o.clear_errors = 1'b1;
					end
				end else if (r.tx_ready) begin
					if (tx_fill != 0) begin
						o.tx_load = 1'b1;
						o.tx_byte = tx_ring[tx_head];
						tx_head = (tx_head + 1) % DEPTH;
						tx_fill--;
					end else begin
						tx_busy = 1'b0;
						irq_en = 1'b0;
					end
				end
			end
			default: ;
		endcase
		o.tx_irq_enable = irq_en;
		o.tx_level = tx_fill[7:0];
		o.rx_level = rx_fill[7:0];
		return o;
	endfunction

	function automatic urbe_pkg::req_item_t make_req(urbe_pkg::func_t f, logic [7:0] b,
			logic rr, logic re, logic tr);
		urbe_pkg::req_item_t r;
		r.func = f;
		r.data_byte = b;
		r.rx_ready = rr;
		r.rx_error = re;
		r.tx_ready = tr;
		return r;
	endfunction

	function automatic urbe_pkg::req_item_t rand_req(mix_t m);
		urbe_pkg::req_item_t r;
		int        pick;
		r = urbe_pkg::req_item_t'($urandom);
		pick = $urandom_range(0, 99);
		case (m)
			MIX_TX_FILL: begin
				if (pick < 92)
					r.func = urbe_pkg::FUNC_WRITE;
				else
					r = make_req(urbe_pkg::FUNC_EVENT, r.data_byte, 1'b0, 1'b0, 1'b1);
			end
			MIX_RX_FILL: begin
				if (pick < 92) begin
					r.func = urbe_pkg::FUNC_EVENT;
					r.rx_ready = 1'b1;
				end else begin
					r.func = urbe_pkg::FUNC_READ;
				end
			end
			MIX_TX_DRAIN: begin
				if (pick < 80)
					r = make_req(urbe_pkg::FUNC_EVENT, r.data_byte, 1'b0, 1'b0, 1'b1);
				else
					r.func = urbe_pkg::FUNC_WRITE;
			end
			MIX_RX_DRAIN: begin
				if (pick < 80)
					r.func = urbe_pkg::FUNC_READ;
				else
					r.func = urbe_pkg::FUNC_EVENT;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int phase_now();
		if (n_sent < total_beats / 3)
			return 0;
		if (n_sent < 2 * total_beats / 3)
			return 1;
		return 2;
	endfunction

	function automatic int send_idle_pct();
		case (phase_now())
			0: return 22;
			1: return 65;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (phase_now())
			0: return 65;
			1: return 22;
			default: return 0;
		endcase
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic check_rsp(urbe_pkg::rsp_item_t want, urbe_pkg::rsp_item_t got);
		check_field("tx_load", 8'(want.tx_load), 8'(got.tx_load));
		check_field("tx_byte", want.tx_byte, got.tx_byte);
		check_field("read_data", want.read_data, got.read_data);
		check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
		check_field("write_accepted", 8'(want.write_accepted), 8'(got.write_accepted));
		check_field("clear_errors", 8'(want.clear_errors), 8'(got.clear_errors));
		check_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(got.tx_irq_enable));
		check_field("tx_level", want.tx_level, got.tx_level);
		check_field("rx_level", want.rx_level, got.rx_level);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_fire) begin
			// hold the beat until taken
		end else if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
			req_ch.valid <= 1'b1;
			req_ch.item <= beat_q.pop_front();
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// long receiver hold-off once the rings start filling
	always @(negedge clk) begin
		if (arst_n && !stall_done && n_sent >= 40) begin
			stall_left <= STALL_CYCLES;
			stall_done <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= arst_n && stall_left == 0 && $urandom_range(0, 99) >= recv_idle_pct();
	end

	// monitor: predict on request beats, check on response beats
	always @(posedge clk) begin
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				rsp_due_q.push_back(uart_step(req_ch.item));
				n_sent <= n_sent + 1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due_q.size() == 0) begin
					$error("response beat with no request outstanding");
					errors++;
				end else begin
					check_rsp(rsp_due_q.pop_front(), rsp_ch.item);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		mix_t mix;
		int   run;

		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.item = '0;
		rsp_ch.ready = 1'b0;
		req_fire = 1'b0;
		n_sent = 0;
		errors = 0;
		cycles = 0;
		stall_left = 0;
		stall_done = 1'b0;
		tx_head = 0;
		tx_tail = 0;
		tx_fill = 0;
		rx_head = 0;
		rx_tail = 0;
		rx_fill = 0;
		tx_busy = 1'b0;
		irq_en = 1'b1;

		// directed: empty rings, idle load, queueing, receive and transmit service paths
		beat_q.push_back(make_req(urbe_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h00, 1'b0, 1'b0, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_WRITE, 8'h00, 1'b0, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'hFF, 1'b0, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'hFF, 1'b1, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h77, 1'b0, 1'b1, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h5A, 1'b1, 1'b1, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h3C, 1'b1, 1'b0, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h00, 1'b0, 1'b0, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h00, 1'b0, 1'b0, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h00, 1'b0, 1'b0, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_NOP, 8'hFF, 1'b1, 1'b1, 1'b1));
		repeat (5)
			beat_q.push_back(make_req(urbe_pkg::FUNC_READ, 8'hFF, 1'b1, 1'b1, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_WRITE, 8'h80, 1'b0, 1'b0, 1'b0));
		beat_q.push_back(make_req(urbe_pkg::FUNC_EVENT, 8'h01, 1'b1, 1'b1, 1'b1));
		beat_q.push_back(make_req(urbe_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0));

		// random: fill both rings past full first, then bursts of mixed traffic
		repeat (170)
			beat_q.push_back(rand_req(MIX_TX_FILL));
		repeat (170)
			beat_q.push_back(rand_req(MIX_RX_FILL));
		while (beat_q.size() < 550) begin
			mix = mix_t'($urandom_range(0, 4));
			run = $urandom_range(10, 50);
			repeat (run) begin
				if (beat_q.size() < 550)
					beat_q.push_back(rand_req(mix));
			end
		end
		total_beats = beat_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_sent != total_beats || rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
